### rtl/i2cms_pkg.sv
// shared types, codes and sizes for the i2c master transaction sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cms_pkg;

  // write buffer sizing
  localparam int BufDepth = 16;
  localparam int BufAw    = $clog2(BufDepth);
  localparam int LptrW    = $clog2(BufDepth + 1);

  // sub-address value that means no register phase
  localparam logic [7:0] NoRegister = 8'hFF;
  // position value that marks a sub-address still to send
  localparam logic [5:0] PosSub     = 6'h3F;

  // stream widths
  localparam int InDataW  = 56;
  localparam int OutDataW = 48;

  typedef enum logic [2:0] {
    KindStartRead  = 3'd0,
    KindStartWrite = 3'd1,
    KindLoadByte   = 3'd2,
    KindStatus     = 3'd3,
    KindError      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BusNone      = 2'd0,
    BusStart     = 2'd1,
    BusStop      = 2'd2,
    BusStopReset = 2'd3
  } bus_cond_e;

  typedef enum logic [1:0] {
    CtlKeep    = 2'd0,
    CtlEnable  = 2'd1,
    CtlDisable = 2'd2
  } ctl_e;

  typedef enum logic [1:0] {
    PosKeep  = 2'd0,
    PosClear = 2'd1,
    PosSet   = 2'd2
  } pos_ctl_e;

  typedef enum logic [1:0] {
    SendNone = 2'd0,
    SendAddr = 2'd1,
    SendData = 2'd2
  } send_kind_e;

  // one request as decoded from the slave side
  typedef struct packed {
    kind_e       kind;
    logic [6:0]  device_address;
    logic [7:0]  sub_address;
    logic [4:0]  byte_count;
    logic [7:0]  data_byte;
    logic [4:0]  status_flags;
    logic [2:0]  error_flags;
    logic        stop_pending;
    logic        start_pending;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
  } req_t;

  // one result as sent on the master side
  typedef struct packed {
    bus_cond_e   bus_condition;
    ctl_e        ack_control;
    pos_ctl_e    pos_control;
    ctl_e        buffer_irq_control;
    ctl_e        event_irq_control;
    send_kind_e  send_kind;
    logic [7:0]  send_value;
    logic [1:0]  rx_count;
    logic [3:0]  rx_index;
    logic [7:0]  rx_byte_first;
    logic [7:0]  rx_byte_second;
    logic        busy_res;
  } res_t;

  // job and sequencing state
  typedef struct packed {
    logic             job_reads;
    logic [6:0]       target_addr;
    logic [7:0]       register_number;
    logic [4:0]       job_length;
    logic             subaddress_done;
    logic             final_stop_flag;
    logic [5:0]       position;
    logic [LptrW-1:0] load_pointer;
    logic             busy_flag;
    logic             events_enabled;
  } seq_state_t;

  // write buffer store
  typedef struct packed {
    logic             we;
    logic [BufAw-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

endpackage

`default_nettype wire

### rtl/i2cms_step.sv
// next-state and result decode for one request of the sequencer
`timescale 1ns / 1ps
`default_nettype none

module i2cms_step (
  input  var i2cms_pkg::req_t       req_i,
  input  var i2cms_pkg::seq_state_t st_i,
  input  wire logic [7:0]           buf_rdata_i,
  output var i2cms_pkg::seq_state_t st_o,
  output var i2cms_pkg::res_t       res_o,
  output var i2cms_pkg::buf_wr_t    buf_wr_o
);

  always_comb begin
    i2cms_pkg::seq_state_t ns;
    i2cms_pkg::res_t       r;
    logic [5:0]            len;
    logic                  rd;
    logic                  start_ok;

    ns       = st_i;
    r        = '0;
    buf_wr_o = '0;
    len      = {1'b0, st_i.job_length};
    rd       = st_i.job_reads & st_i.subaddress_done;
    start_ok = (req_i.kind == i2cms_pkg::KindStartRead) ||
               ((req_i.kind == i2cms_pkg::KindStartWrite) &&
                (7'(req_i.byte_count) <= 7'(i2cms_pkg::BufDepth)));

    if (start_ok) begin
      // new job replaces any job in progress
      ns.job_reads       = (req_i.kind == i2cms_pkg::KindStartRead);
      ns.target_addr     = req_i.device_address;
      ns.register_number = req_i.sub_address;
      ns.job_length      = req_i.byte_count;
      ns.busy_flag       = 1'b1;
      if (req_i.kind == i2cms_pkg::KindStartWrite) begin
        ns.load_pointer = '0;
      end
      if (!st_i.events_enabled) begin
        if (!req_i.start_pending) begin
          r.bus_condition = i2cms_pkg::BusStart;
        end
        r.event_irq_control = i2cms_pkg::CtlEnable;
        ns.events_enabled   = 1'b1;
      end
    end else begin
      case (req_i.kind)
        i2cms_pkg::KindLoadByte: begin
          // append payload until the buffer is full
          if (32'(st_i.load_pointer) < i2cms_pkg::BufDepth) begin
            buf_wr_o.we     = 1'b1;
            buf_wr_o.addr   = st_i.load_pointer[i2cms_pkg::BufAw-1:0];
            buf_wr_o.data   = req_i.data_byte;
            ns.load_pointer = st_i.load_pointer + {{(i2cms_pkg::LptrW-1){1'b0}}, 1'b1};
          end
        end
        i2cms_pkg::KindStatus: begin
          // flags in priority order
          if (req_i.status_flags[0]) begin
            r.pos_control = i2cms_pkg::PosClear;
            r.ack_control = i2cms_pkg::CtlEnable;
            r.send_kind   = i2cms_pkg::SendAddr;
            ns.position   = '0;
            if (st_i.job_reads && (st_i.subaddress_done ||
                (st_i.register_number == i2cms_pkg::NoRegister))) begin
              ns.subaddress_done = 1'b1;
              if (len == 6'd2) begin
                r.pos_control = i2cms_pkg::PosSet;
              end
              r.send_value = {st_i.target_addr, 1'b1};
            end else begin
              r.send_value = {st_i.target_addr, 1'b0};
              if (st_i.register_number != i2cms_pkg::NoRegister) begin
                ns.position = i2cms_pkg::PosSub;
              end
            end
          end else if (req_i.status_flags[1]) begin
            if (rd && (len == 6'd1)) begin
              r.ack_control        = i2cms_pkg::CtlDisable;
              r.bus_condition      = i2cms_pkg::BusStop;
              ns.final_stop_flag   = 1'b1;
              r.buffer_irq_control = i2cms_pkg::CtlEnable;
            end else if (rd && (len == 6'd2)) begin
              r.ack_control        = i2cms_pkg::CtlDisable;
              r.buffer_irq_control = i2cms_pkg::CtlDisable;
            end else if (rd && (len == 6'd3)) begin
              r.buffer_irq_control = i2cms_pkg::CtlDisable;
            end else begin
              r.buffer_irq_control = i2cms_pkg::CtlEnable;
            end
          end else if (req_i.status_flags[2]) begin
            ns.final_stop_flag = 1'b1;
            if (rd) begin
              r.rx_count       = 2'd2;
              r.rx_index       = st_i.position[3:0];
              r.rx_byte_first  = req_i.rx_first;
              r.rx_byte_second = req_i.rx_second;
              r.bus_condition  = i2cms_pkg::BusStop;
              if (len > 6'd2) begin
                r.ack_control        = i2cms_pkg::CtlDisable;
                r.buffer_irq_control = i2cms_pkg::CtlEnable;
                ns.position          = st_i.position + 6'd2;
              end else begin
                ns.position = st_i.position + 6'd3;
              end
            end else if (st_i.subaddress_done || !st_i.job_reads) begin
              r.bus_condition = i2cms_pkg::BusStop;
              ns.position     = st_i.position + 6'd1;
            end else begin
              // repeated start for the read phase
              r.bus_condition    = i2cms_pkg::BusStart;
              ns.subaddress_done = 1'b1;
            end
          end else if (req_i.status_flags[3]) begin
            r.rx_count      = 2'd1;
            r.rx_index      = st_i.position[3:0];
            r.rx_byte_first = req_i.rx_first;
            ns.position     = st_i.position + 6'd1;
            if (len == (ns.position + 6'd3)) begin
              r.buffer_irq_control = i2cms_pkg::CtlDisable;
            end
            if (len == ns.position) begin
              ns.position = ns.position + 6'd1;
            end
          end else if (req_i.status_flags[4]) begin
            r.send_kind = i2cms_pkg::SendData;
            if (st_i.position != i2cms_pkg::PosSub) begin
              r.send_value = buf_rdata_i;
              ns.position  = st_i.position + 6'd1;
              if (len == ns.position) begin
                r.buffer_irq_control = i2cms_pkg::CtlDisable;
              end
            end else begin
              ns.position  = '0;
              r.send_value = st_i.register_number;
              if (st_i.job_reads || (len == 6'd0)) begin
                r.buffer_irq_control = i2cms_pkg::CtlDisable;
              end
            end
          end
          // completion check runs on every status request
          if (ns.position == (len + 6'd1)) begin
            ns.subaddress_done = 1'b0;
            if (ns.final_stop_flag) begin
              r.event_irq_control = i2cms_pkg::CtlDisable;
              ns.events_enabled   = 1'b0;
            end
            ns.busy_flag = 1'b0;
          end
        end
        i2cms_pkg::KindError: begin
          if (req_i.error_flags != 3'd0) begin
            r.buffer_irq_control = i2cms_pkg::CtlDisable;
            if (!req_i.error_flags[1] && !req_i.stop_pending) begin
              r.bus_condition = req_i.start_pending ? i2cms_pkg::BusStopReset
                                                    : i2cms_pkg::BusStop;
              r.event_irq_control = i2cms_pkg::CtlDisable;
              ns.events_enabled   = 1'b0;
            end
          end
          ns.busy_flag = 1'b0;
        end
        default: begin
          // oversized write job and unknown kinds change nothing
        end
      endcase
    end

    r.busy_res = ns.busy_flag;
    st_o       = ns;
    res_o      = r;
  end

endmodule

`default_nettype wire

### rtl/i2c_master_transaction_sequencer.sv
// top level of the i2c master register read and write sequencer
// Usage: software requests arrive on the slave stream (s_axis_*): tuser carries
// the request kind (start read job, start write job, load write byte, status
// event, error event) and tdata the job fields, peripheral flags and data
// register values. Each request produces exactly one result on the master
// stream (m_axis_*): bus condition, ack/pos/interrupt controls, the byte to
// send (its kind in tuser), up to two received bytes and the busy flag.
// The result is registered: it is valid in the cycle after its request is taken.
// Throughput: one request per cycle while the result is not stalled; the decode
// is a single combinational pass from the job state registers into the result
// register. Stall: the result register holds while m_axis_tready_i is low; a new
// request is still taken in a cycle where the held result is drained.
// Reset: all job state clears, as an idle zero-length write job; the 16-byte
// write buffer has no reset; users must load it before reads (not enforced).
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: device_address[6:0], sub_address[14:7], byte_count[19:15],
  // data_byte[27:20], status_flags[32:28], error_flags[35:33],
  // stop_pending[36], start_pending[37], rx_first[45:38], rx_second[53:46]
  input  wire logic [i2cms_pkg::InDataW-1:0]      s_axis_tdata_i,
  // tuser: kind[2:0]
  input  wire logic [2:0]                         s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: bus_condition[1:0], ack_control[3:2], pos_control[5:4],
  // buffer_irq_control[7:6], event_irq_control[9:8], send_value[17:10],
  // rx_count[19:18], rx_index[23:20], rx_byte_first[31:24],
  // rx_byte_second[39:32], busy_res[40]
  output logic [i2cms_pkg::OutDataW-1:0]          m_axis_tdata_o,
  // tuser: send_kind[1:0]
  output logic [1:0]                              m_axis_tuser_o
);

  i2cms_pkg::req_t       req;
  i2cms_pkg::seq_state_t st_q, st_d;
  i2cms_pkg::res_t       res_q, res_d;
  i2cms_pkg::buf_wr_t    buf_wr;
  logic                  out_valid_q;
  logic                  req_acc;
  logic [7:0]            buf_rdata;
  logic [7:0]            wbuf_q [i2cms_pkg::BufDepth];

  // unpack the request
  assign req.kind           = i2cms_pkg::kind_e'(s_axis_tuser_i);
  assign req.device_address = s_axis_tdata_i[6:0];
  assign req.sub_address    = s_axis_tdata_i[14:7];
  assign req.byte_count     = s_axis_tdata_i[19:15];
  assign req.data_byte      = s_axis_tdata_i[27:20];
  assign req.status_flags   = s_axis_tdata_i[32:28];
  assign req.error_flags    = s_axis_tdata_i[35:33];
  assign req.stop_pending   = s_axis_tdata_i[36];
  assign req.start_pending  = s_axis_tdata_i[37];
  assign req.rx_first       = s_axis_tdata_i[45:38];
  assign req.rx_second      = s_axis_tdata_i[53:46];

  // take a request whenever the result register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign req_acc         = s_axis_tvalid_i && s_axis_tready_o;

  // write buffer read at the current position, zero beyond the buffer
  assign buf_rdata = ({1'b0, st_q.position} < 7'(i2cms_pkg::BufDepth)) ?
                     wbuf_q[st_q.position[i2cms_pkg::BufAw-1:0]] : 8'h00;

  i2cms_step u_step (
    .req_i       (req),
    .st_i        (st_q),
    .buf_rdata_i (buf_rdata),
    .st_o        (st_d),
    .res_o       (res_d),
    .buf_wr_o    (buf_wr)
  );

  // job state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (req_acc) begin
      st_q <= st_d;
    end
  end

  // write buffer
  always_ff @(posedge clk_i) begin
    if (req_acc && buf_wr.we) begin
      wbuf_q[buf_wr.addr] <= buf_wr.data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_acc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      res_q <= res_d;
    end
  end

  // pack the result
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.send_kind;
  assign m_axis_tdata_o  = {7'd0, res_q.busy_res, res_q.rx_byte_second,
                            res_q.rx_byte_first, res_q.rx_index, res_q.rx_count,
                            res_q.send_value, res_q.event_irq_control,
                            res_q.buffer_irq_control, res_q.pos_control,
                            res_q.ack_control, res_q.bus_condition};

`ifndef SYNTHESIS
  // load pointer never runs past the buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(st_q.load_pointer) <= i2cms_pkg::BufDepth)
    else $error("load pointer beyond write buffer");

  // a request is never taken over a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && out_valid_q) |-> m_axis_tready_i)
    else $error("result overwritten while stalled");

  // an error request always ends the job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req.kind == i2cms_pkg::KindError)) |=>
      (m_axis_tvalid_o && !res_q.busy_res && !st_q.busy_flag))
    else $error("busy after error request");

  // a started read job is busy with events enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (req.kind == i2cms_pkg::KindStartRead)) |=>
      (st_q.busy_flag && st_q.events_enabled && res_q.busy_res))
    else $error("read job start not registered");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// self-checking testbench for the i2c master transaction sequencer
`timescale 1ns / 1ps

module tb;

  // peripheral status flag bits, one per event source
  localparam logic [4:0] FlagStartSent = 5'b00001;
  localparam logic [4:0] FlagAddrSent  = 5'b00010;
  localparam logic [4:0] FlagByteDone  = 5'b00100;
  localparam logic [4:0] FlagRxFull    = 5'b01000;
  localparam logic [4:0] FlagTxEmpty   = 5'b10000;

  // highest code that fits the kind field, past the defined kinds
  localparam int KindLastCode = 7;

  localparam int StallLimit   = 4000;
  localparam int RandomItems  = 1600;
  localparam int PrintLimit   = 100;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [i2cms_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic [2:0]                     s_axis_tuser_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [i2cms_pkg::OutDataW-1:0] m_axis_tdata_o;
  logic [1:0]                     m_axis_tuser_o;

  i2c_master_transaction_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the sequencer state, reset values
  logic       seq_reads      = 1'b0;
  logic [7:0] seq_target     = '0;
  logic [7:0] seq_register   = '0;
  logic [4:0] seq_length     = '0;
  logic       seq_sub_done   = 1'b0;
  logic       seq_final_stop = 1'b0;
  logic [5:0] seq_position   = '0;
  logic       seq_busy       = 1'b0;
  logic       seq_events_on  = 1'b0;
  logic [7:0] shadow_buffer [i2cms_pkg::BufDepth];
  bit         slot_loaded [i2cms_pkg::BufDepth];
  int         load_ptr = 0;

  // controls predicted for requests not yet taken, and for taken ones
  i2cms_pkg::res_t in_flight_controls[$];
  i2cms_pkg::res_t awaited_controls[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_items     = 0;
  int mismatch_count = 0;
  int quiet_cycles   = 0;

  typedef struct {
    i2cms_pkg::req_t req;
    bit              typed;
    i2cms_pkg::res_t want;
  } row_t;

  row_t directed_rows[$];

  // controls and received bytes that one request should produce
  function automatic i2cms_pkg::res_t predict_controls(input i2cms_pkg::req_t r);
    i2cms_pkg::res_t o;
    logic [5:0]      len6;
    logic            rd;
    o = '0;
    len6 = {1'b0, seq_length};
    rd = seq_reads && seq_sub_done;
    if (r.kind == i2cms_pkg::KindStartRead ||
        (r.kind == i2cms_pkg::KindStartWrite && r.byte_count <= i2cms_pkg::BufDepth)) begin
      // new job replaces the old one
      seq_reads    = (r.kind == i2cms_pkg::KindStartRead);
      seq_target   = {r.device_address, 1'b0};
      seq_register = r.sub_address;
      seq_length   = r.byte_count;
      seq_busy     = 1'b1;
      if (r.kind == i2cms_pkg::KindStartWrite) load_ptr = 0;
      if (!seq_events_on) begin
        if (!r.start_pending) o.bus_condition = i2cms_pkg::BusStart;
        o.event_irq_control = i2cms_pkg::CtlEnable;
        seq_events_on = 1'b1;
      end
    end else if (r.kind == i2cms_pkg::KindLoadByte) begin
      // bytes past a full buffer are dropped
      if (load_ptr < i2cms_pkg::BufDepth) begin
        shadow_buffer[load_ptr] = r.data_byte;
        slot_loaded[load_ptr] = 1'b1;
        load_ptr++;
      end
    end else if (r.kind == i2cms_pkg::KindStatus) begin
      // events taken in priority order, lowest flag first
      if (r.status_flags[0]) begin
        o.pos_control = i2cms_pkg::PosClear;
        o.ack_control = i2cms_pkg::CtlEnable;
        o.send_kind = i2cms_pkg::SendAddr;
        seq_position = '0;
        if (seq_reads && (seq_sub_done || seq_register == i2cms_pkg::NoRegister)) begin
          seq_sub_done = 1'b1;
          if (seq_length == 5'd2) o.pos_control = i2cms_pkg::PosSet;
          o.send_value = seq_target | 8'h01;
        end else begin
          o.send_value = seq_target & 8'hFE;
          if (seq_register != i2cms_pkg::NoRegister) seq_position = i2cms_pkg::PosSub;
        end
      end else if (r.status_flags[1]) begin
        if (seq_length == 5'd1 && rd) begin
          o.ack_control = i2cms_pkg::CtlDisable;
          o.bus_condition = i2cms_pkg::BusStop;
          o.buffer_irq_control = i2cms_pkg::CtlEnable;
          seq_final_stop = 1'b1;
        end else if (seq_length == 5'd2 && rd) begin
          o.ack_control = i2cms_pkg::CtlDisable;
          o.buffer_irq_control = i2cms_pkg::CtlDisable;
        end else if (seq_length == 5'd3 && rd) begin
          o.buffer_irq_control = i2cms_pkg::CtlDisable;
        end else begin
          o.buffer_irq_control = i2cms_pkg::CtlEnable;
        end
      end else if (r.status_flags[2]) begin
        seq_final_stop = 1'b1;
        if (rd) begin
          o.rx_count = 2'd2;
          o.rx_index = seq_position[3:0];
          o.rx_byte_first = r.rx_first;
          o.rx_byte_second = r.rx_second;
          o.bus_condition = i2cms_pkg::BusStop;
          if (seq_length > 5'd2) begin
            o.ack_control = i2cms_pkg::CtlDisable;
            o.buffer_irq_control = i2cms_pkg::CtlEnable;
            seq_position += 6'd2;
          end else begin
            seq_position += 6'd3;
          end
        end else if (seq_sub_done || !seq_reads) begin
          // final stop was just set
          o.bus_condition = i2cms_pkg::BusStop;
          seq_position += 6'd1;
        end else begin
          // sub-address written, restart for the read phase
          o.bus_condition = i2cms_pkg::BusStart;
          seq_sub_done = 1'b1;
        end
      end else if (r.status_flags[3]) begin
        o.rx_count = 2'd1;
        o.rx_index = seq_position[3:0];
        o.rx_byte_first = r.rx_first;
        seq_position += 6'd1;
        if (len6 == seq_position + 6'd3) o.buffer_irq_control = i2cms_pkg::CtlDisable;
        if (len6 == seq_position) seq_position += 6'd1;
      end else if (r.status_flags[4]) begin
        o.send_kind = i2cms_pkg::SendData;
        if (seq_position != i2cms_pkg::PosSub) begin
          o.send_value = (seq_position < i2cms_pkg::BufDepth) ?
                         shadow_buffer[seq_position[3:0]] : 8'h00;
          seq_position += 6'd1;
          if (len6 == seq_position) o.buffer_irq_control = i2cms_pkg::CtlDisable;
        end else begin
          seq_position = '0;
          o.send_value = seq_register;
          if (seq_reads || seq_length == 5'd0) o.buffer_irq_control = i2cms_pkg::CtlDisable;
        end
      end
      // completion check, runs even with no flag set
      if (seq_position == len6 + 6'd1) begin
        seq_sub_done = 1'b0;
        if (seq_final_stop) begin
          o.event_irq_control = i2cms_pkg::CtlDisable;
          seq_events_on = 1'b0;
        end
        seq_busy = 1'b0;
      end
    end else if (r.kind == i2cms_pkg::KindError) begin
      if (r.error_flags != 3'd0) begin
        o.buffer_irq_control = i2cms_pkg::CtlDisable;
        if (!r.error_flags[1] && !r.stop_pending) begin
          o.bus_condition = r.start_pending ? i2cms_pkg::BusStopReset : i2cms_pkg::BusStop;
          o.event_irq_control = i2cms_pkg::CtlDisable;
          seq_events_on = 1'b0;
        end
      end
      seq_busy = 1'b0;
    end
    o.busy_res = seq_busy;
    return o;
  endfunction

  function automatic i2cms_pkg::req_t random_request(input i2cms_pkg::kind_e k);
    i2cms_pkg::req_t r;
    r.kind           = k;
    r.device_address = 7'($urandom);
    r.sub_address    = 8'($urandom);
    r.byte_count     = 5'($urandom);
    r.data_byte      = 8'($urandom);
    r.status_flags   = 5'($urandom);
    r.error_flags    = 3'($urandom);
    r.stop_pending   = 1'($urandom);
    r.start_pending  = 1'($urandom);
    r.rx_first       = 8'($urandom);
    r.rx_second      = 8'($urandom);
    return r;
  endfunction

  function automatic i2cms_pkg::res_t hand_result(input i2cms_pkg::bus_cond_e bus,
                                                  input i2cms_pkg::ctl_e buf_irq,
                                                  input i2cms_pkg::ctl_e ev_irq,
                                                  input logic busy);
    i2cms_pkg::res_t o;
    o = '0;
    o.bus_condition = bus;
    o.buffer_irq_control = buf_irq;
    o.event_irq_control = ev_irq;
    o.busy_res = busy;
    return o;
  endfunction

  // a is address, data byte, status or error flags; pend is {start, stop}
  task automatic add_row(input i2cms_pkg::kind_e k, input logic [7:0] a,
                         input logic [7:0] b, input logic [4:0] c,
                         input logic [1:0] pend, input logic [15:0] rx,
                         input bit typed, input i2cms_pkg::res_t want);
    row_t row;
    row.req = '0;
    row.req.kind           = k;
    row.req.device_address = a[6:0];
    row.req.data_byte      = a;
    row.req.status_flags   = a[4:0];
    row.req.error_flags    = a[2:0];
    row.req.sub_address    = b;
    row.req.byte_count     = c;
    row.req.start_pending  = pend[1];
    row.req.stop_pending   = pend[0];
    row.req.rx_first       = rx[7:0];
    row.req.rx_second      = rx[15:8];
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // present one request and wait until it is taken
  task automatic issue_request(input i2cms_pkg::req_t r, input bit typed,
                               input i2cms_pkg::res_t want);
    i2cms_pkg::res_t predicted;
    // never send from a buffer slot that was not loaded
    if (r.kind == i2cms_pkg::KindStatus && r.status_flags[3:0] == 4'd0 &&
        r.status_flags[4] && seq_position != i2cms_pkg::PosSub &&
        seq_position < i2cms_pkg::BufDepth && !slot_loaded[seq_position[3:0]])
      r.status_flags[3] = 1'b1;
    predicted = predict_controls(r);
    in_flight_controls.push_back(typed ? want : predicted);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= {2'b00, r.rx_second, r.rx_first, r.start_pending, r.stop_pending,
                        r.error_flags, r.status_flags, r.data_byte, r.byte_count,
                        r.sub_address, r.device_address};
    s_axis_tuser_i  <= r.kind;
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sent_items++;
  endtask

  // hold off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (in_flight_controls.size() != 0 || awaited_controls.size() != 0) @(posedge clk_i);
  endtask

  // one job: start, loads, a clean flag sequence with noise mixed in
  task automatic random_job();
    i2cms_pkg::req_t r;
    logic [4:0]      script[$];
    int              count;
    int              extra;
    int              i;
    bit              reads;
    bit              has_sub;
    bit              abandoned;
    reads = 1'($urandom);
    count = ($urandom_range(0, 11) == 0) ? $urandom_range(5, 31) : $urandom_range(0, 4);
    has_sub = 1'($urandom);
    r = random_request(reads ? i2cms_pkg::KindStartRead : i2cms_pkg::KindStartWrite);
    r.byte_count = 5'(count);
    if (!has_sub) r.sub_address = i2cms_pkg::NoRegister;
    else if (r.sub_address == i2cms_pkg::NoRegister) r.sub_address = 8'h00;
    r.start_pending = ($urandom_range(0, 7) == 0);
    r.stop_pending  = ($urandom_range(0, 7) == 0);
    issue_request(r, 1'b0, '0);
    if (!reads) begin
      extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
      for (i = 0; i < count + extra; i++)
        issue_request(random_request(i2cms_pkg::KindLoadByte), 1'b0, '0);
    end
    // flag order a peripheral would report for a clean transfer
    if (reads && has_sub) begin
      script.push_back(FlagStartSent);
      script.push_back(FlagAddrSent);
      script.push_back(FlagTxEmpty);
      script.push_back(FlagByteDone);
    end
    script.push_back(FlagStartSent);
    script.push_back(FlagAddrSent);
    if (!reads && has_sub) script.push_back(FlagTxEmpty);
    for (i = 0; i < count; i++) script.push_back(reads ? FlagRxFull : FlagTxEmpty);
    script.push_back(FlagByteDone);
    abandoned = 1'b0;
    for (i = 0; i < script.size() && !abandoned; i++) begin
      if ($urandom_range(0, 99) < 4) begin
        issue_request(random_request(i2cms_pkg::KindError), 1'b0, '0);
        abandoned = 1'b1;
      end else begin
        r = random_request(i2cms_pkg::KindStatus);
        if ($urandom_range(0, 99) >= 15) r.status_flags = script[i];
        issue_request(r, 1'b0, '0);
        if ($urandom_range(0, 99) < 3) begin
          if (1'($urandom))
            issue_request(random_request(i2cms_pkg::KindLoadByte), 1'b0, '0);
          else
            issue_request(random_request(i2cms_pkg::kind_e'(3'($urandom_range(
                            int'(i2cms_pkg::KindError) + 1, KindLastCode)))),
                          1'b0, '0);
        end
      end
    end
    if ($urandom_range(0, 4) == 0)
      issue_request(random_request(i2cms_pkg::KindError), 1'b0, '0);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PrintLimit) $display("tb: mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endtask

  // receiver readiness
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checking, then request bookkeeping
  always @(posedge clk_i) begin
    i2cms_pkg::res_t want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_controls.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = awaited_controls.pop_front();
        check_field("bus_condition", want.bus_condition, m_axis_tdata_o[1:0]);
        check_field("ack_control", want.ack_control, m_axis_tdata_o[3:2]);
        check_field("pos_control", want.pos_control, m_axis_tdata_o[5:4]);
        check_field("buffer_irq_control", want.buffer_irq_control, m_axis_tdata_o[7:6]);
        check_field("event_irq_control", want.event_irq_control, m_axis_tdata_o[9:8]);
        check_field("send_value", want.send_value, m_axis_tdata_o[17:10]);
        check_field("rx_count", want.rx_count, m_axis_tdata_o[19:18]);
        check_field("rx_index", want.rx_index, m_axis_tdata_o[23:20]);
        check_field("rx_byte_first", want.rx_byte_first, m_axis_tdata_o[31:24]);
        check_field("rx_byte_second", want.rx_byte_second, m_axis_tdata_o[39:32]);
        check_field("busy_res", want.busy_res, m_axis_tdata_o[40]);
        check_field("tdata padding", '0, m_axis_tdata_o[i2cms_pkg::OutDataW-1:41]);
        check_field("send_kind", want.send_kind, m_axis_tuser_o);
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o && in_flight_controls.size() != 0)
      awaited_controls.push_back(in_flight_controls.pop_front());
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int phase;
    int goal;
    // after reset, extremes, each event source, job restarts and error cases
    add_row(i2cms_pkg::KindStatus, 8'h00, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlKeep, i2cms_pkg::CtlKeep, 1'b0));
    add_row(i2cms_pkg::KindError, 8'h00, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlKeep, i2cms_pkg::CtlKeep, 1'b0));
    add_row(i2cms_pkg::KindStartWrite, 8'h7F, i2cms_pkg::NoRegister, 5'd2, 2'b00,
            16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusStart, i2cms_pkg::CtlKeep, i2cms_pkg::CtlEnable,
                        1'b1));
    add_row(i2cms_pkg::KindLoadByte, 8'h00, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindLoadByte, 8'hFF, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, 8'h1F, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, 8'h1E, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagTxEmpty, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagTxEmpty, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagByteDone, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStartRead, 8'h00, 8'h00, 5'd2, 2'b10, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlKeep, i2cms_pkg::CtlEnable,
                        1'b1));
    add_row(i2cms_pkg::KindStatus, FlagStartSent, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagAddrSent, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagTxEmpty, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagByteDone, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagStartSent, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagAddrSent, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagByteDone, 8'h00, 5'd0, 2'b00, 16'hA55A, 1'b0, '0);
    add_row(i2cms_pkg::KindStartRead, 8'h55, i2cms_pkg::NoRegister, 5'd31, 2'b00,
            16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusStart, i2cms_pkg::CtlKeep, i2cms_pkg::CtlEnable,
                        1'b1));
    add_row(i2cms_pkg::KindStatus, FlagStartSent, 8'h00, 5'd0, 2'b00, 16'h0000, 1'b0, '0);
    add_row(i2cms_pkg::KindStatus, FlagRxFull, 8'h00, 5'd0, 2'b00, 16'h00FF, 1'b0, '0);
    // oversized write job is ignored, job stays busy
    add_row(i2cms_pkg::KindStartWrite, 8'h12, 8'h34, 5'd17, 2'b00, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlKeep, i2cms_pkg::CtlKeep, 1'b1));
    add_row(i2cms_pkg::KindError, 8'h07, 8'h00, 5'd0, 2'b10, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlDisable, i2cms_pkg::CtlKeep,
                        1'b0));
    add_row(i2cms_pkg::KindError, 8'h01, 8'h00, 5'd0, 2'b10, 16'h0000, 1'b1,
            hand_result(i2cms_pkg::BusStopReset, i2cms_pkg::CtlDisable,
                        i2cms_pkg::CtlDisable, 1'b0));
    add_row(i2cms_pkg::kind_e'(3'(KindLastCode)), 8'hFF, 8'hFF, 5'd31, 2'b11, 16'hFFFF,
            1'b1,
            hand_result(i2cms_pkg::BusNone, i2cms_pkg::CtlKeep, i2cms_pkg::CtlKeep, 1'b0));

    send_idle_pct  = 8;
    recv_stall_pct = 82;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // three idling regimes, each ending with a full drain
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 8 : (phase == 1) ? 82 : 0;
      recv_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 8 : 0;
      goal = directed_rows.size() + (phase + 1) * (RandomItems / 3);
      while (sent_items < goal) random_job();
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_controls.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
